FILE: rtl/core/cctc_pkg.sv
`default_nettype none

package cctc_pkg;

  localparam int CHANNELS        = 4;
  localparam int CHAN_W          = 2;
  localparam int PERIOD_BITS_DEF = 50;
  // headroom above the period width in the shared accumulator
  localparam int ACC_EXT_BITS    = 16;
  localparam int TC_BITS         = 8;

  localparam logic [7:0] VECTOR_BASE_RST = 8'h10;

  // input periods at reset: channels 0/1 run off clk/2
  localparam int IP_RST_SYSCLK  = 2;
  localparam int IP_RST_CASCADE = 1;

  // cascade chain: channel 0 feeds channel 2, channel 2 feeds channel 3
  localparam logic [CHAN_W-1:0] CH_CASC_SRC_A = 2'd0;
  localparam logic [CHAN_W-1:0] CH_CASC_DST_A = 2'd2;
  localparam logic [CHAN_W-1:0] CH_CASC_SRC_B = 2'd2;
  localparam logic [CHAN_W-1:0] CH_CASC_DST_B = 2'd3;
  localparam logic [CHAN_W-1:0] CH_LAST       = 2'd3;

  // control word bit positions
  localparam int CTRL_IE         = 7;
  localparam int CTRL_CASCADE    = 6;
  localparam int CTRL_PRE256     = 5;
  localparam int CTRL_TC_FOLLOWS = 2;
  localparam int CTRL_STOP       = 1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_IRQ  = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    PS_NONE = 2'd0,
    PS_1    = 2'd1,
    PS_16   = 2'd2,
    PS_256  = 2'd3
  } prescale_e;

  typedef enum logic [1:0] {
    ALU_MUL = 2'd0,
    ALU_DIV = 2'd1,
    ALU_SUB = 2'd2,
    ALU_ADD = 2'd3
  } alu_mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_MUL_END,
    S_DIV,
    S_RD_OUT,
    S_TK_SUB,
    S_TK_ADD,
    S_TK_OUT
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/core/four_channel_cascaded_ctc.sv
`default_nettype none

// Four-channel counter/timer with cascade (channel 0 feeds channel 2, channel 2
// feeds channel 3). An item is taken on start_i while busy_o is low; busy_o stays
// high until every result of that item has been strobed on out_valid_o, and the
// receiver cannot stall them. All work runs on one shared adder under a small
// sequencer. A write runs four 8-step multiplies, each with a saturate/commit step,
// and gives no result. A read runs a restoring divide, one step per cycle, unless
// the channel's input period is zero, and ends with its reply. A tick decrements
// and reloads each channel and, when any channel fires, then strobes the interrupt
// requests in channel order (one per firing channel, up to the last one that fires).
// vector_base is written through cfg_we_i/cfg_data_i; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module four_channel_cascaded_ctc
  import cctc_pkg::*;
#(
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire logic [1:0]             cmd_i,
  input  wire logic [CHAN_W-1:0]      channel_i,
  input  wire logic [7:0]             data_i,
  input  wire logic [15:0]            cycles_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [7:0]             cfg_data_i,
  output logic                        out_valid_o,
  output logic                        kind_o,
  output logic [CHAN_W-1:0]           source_channel_o,
  output logic [7:0]                  read_value_o,
  output logic [PERIOD_BITS-1:0]      period_o,
  output logic [7:0]                  irq_vector_o,
  output logic                        last_o
);

  localparam int W   = PERIOD_BITS + ACC_EXT_BITS;
  localparam int RW  = PERIOD_BITS + 1;          // signed count width
  localparam int ITW = $clog2(PERIOD_BITS + 2);

  // architectural per-channel state
  logic [7:0]             vector_base_q;
  logic                   ie_q   [CHANNELS];
  logic                   run_q  [CHANNELS];
  logic                   cs_q   [CHANNELS];   // 1: system clock, 0: cascade
  logic                   pend_q [CHANNELS];
  logic [TC_BITS-1:0]     tc_q   [CHANNELS];
  prescale_e              ps_q   [CHANNELS];
  logic [PERIOD_BITS-1:0] ip_q   [CHANNELS];
  logic [PERIOD_BITS-1:0] op_q   [CHANNELS];
  logic [RW-1:0]          rem_q  [CHANNELS];

  // sequencer
  state_e                 state_q, state_d;
  logic [CHAN_W-1:0]      k_q;
  logic [ITW-1:0]         it_q;
  logic [CHANNELS-1:0]    fire_q;

  // working registers
  logic [W-1:0]           acc_q;
  logic [RW-1:0]          n_q;      // dividend magnitude, shifted out MSB first
  logic [7:0]             quo_q;    // low byte of quotient magnitude
  logic                   neg_q;
  logic [15:0]            cycles_q;

  // shared adder hookup
  alu_mode_e              alu_mode;
  logic [W-1:0]           alu_acc;
  logic [PERIOD_BITS-1:0] alu_opnd;
  logic                   alu_bit;
  logic [W-1:0]           alu_sum;

  logic [TC_BITS-1:0]     tc_eff;
  logic [RW-1:0]          rem_k;
  logic [W-1:0]           rem_ext;
  logic [W-1:0]           prod_full;
  logic                   prod_sat;
  logic [PERIOD_BITS-1:0] prod;
  logic                   div_ge;
  logic                   sub_fits;
  logic [RW-1:0]          rem_after_sub;
  logic                   rem_le0;
  logic                   later_fire;
  logic                   accept;
  logic [RW-1:0]          rem_sel;

  assign accept  = start_i && !busy_o;
  assign rem_k   = rem_q[k_q];
  assign rem_ext = {{(W - RW){rem_k[RW-1]}}, rem_k};
  assign tc_eff  = (ps_q[k_q] == PS_NONE) ? '0 : tc_q[k_q];
  assign rem_sel = rem_q[channel_i];

  always_comb begin
    alu_acc  = rem_ext;
    alu_opnd = op_q[k_q];
    alu_bit  = 1'b0;
    case (state_q)
      S_MUL: begin
        alu_mode = ALU_MUL;
        alu_acc  = acc_q;
        alu_opnd = cs_q[k_q] ? PERIOD_BITS'(1) : ip_q[k_q];
        alu_bit  = tc_eff[3'(TC_BITS - 1) - it_q[2:0]];
      end
      S_DIV: begin
        alu_mode = ALU_DIV;
        alu_acc  = acc_q;
        alu_opnd = ip_q[k_q];
        alu_bit  = n_q[RW-1];
      end
      S_TK_SUB: begin
        alu_mode = ALU_SUB;
        alu_opnd = PERIOD_BITS'(cycles_q);
      end
      default: begin
        alu_mode = ALU_ADD;
      end
    endcase
  end

  cctc_alu #(
    .PERIOD_BITS(PERIOD_BITS)
  ) u_alu (
    .mode_i (alu_mode),
    .acc_i  (alu_acc),
    .opnd_i (alu_opnd),
    .bit_i  (alu_bit),
    .sum_o  (alu_sum)
  );

  // prescale is a power of two: apply it as a shift after tc * input period
  always_comb begin
    case (ps_q[k_q])
      PS_16:   prod_full = acc_q << 4;
      PS_256:  prod_full = acc_q << 8;
      default: prod_full = acc_q;
    endcase
  end
  assign prod_sat = |prod_full[W-1:PERIOD_BITS];
  assign prod     = prod_sat ? '1 : prod_full[PERIOD_BITS-1:0];

  // divide step: no borrow means the trial subtract stands
  assign div_ge = !alu_sum[W-1];

  // count floor is -2^PERIOD_BITS; result fits iff the upper bits are a sign run
  assign sub_fits      = (&alu_sum[W-1:PERIOD_BITS]) || !(|alu_sum[W-1:PERIOD_BITS]);
  assign rem_after_sub = sub_fits ? alu_sum[RW-1:0] : {1'b1, {PERIOD_BITS{1'b0}}};
  assign rem_le0       = rem_k[RW-1] || (rem_k == '0);

  always_comb begin
    later_fire = 1'b0;
    for (int j = 0; j < CHANNELS; j++) begin
      if (CHAN_W'(j) > k_q && fire_q[j]) begin
        later_fire = 1'b1;
      end
    end
  end

  // next state and result outputs
  always_comb begin
    state_d          = state_q;
    out_valid_o      = 1'b0;
    kind_o           = KIND_READ;
    source_channel_o = k_q;
    read_value_o     = '0;
    period_o         = op_q[k_q];
    irq_vector_o     = '0;
    last_o           = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (cmd_i)
            CMD_WRITE: state_d = S_MUL;
            CMD_READ:  state_d = (ip_q[channel_i] == '0) ? S_RD_OUT : S_DIV;
            CMD_TICK:  state_d = S_TK_SUB;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        if (it_q == ITW'(TC_BITS - 1)) state_d = S_MUL_END;
      end
      S_MUL_END: begin
        state_d = (k_q == CH_LAST) ? S_IDLE : S_MUL;
      end
      S_DIV: begin
        if (it_q == ITW'(PERIOD_BITS)) state_d = S_RD_OUT;
      end
      S_RD_OUT: begin
        out_valid_o  = 1'b1;
        kind_o       = KIND_READ;
        read_value_o = neg_q ? 8'(8'd0 - quo_q) : quo_q;
        last_o       = 1'b1;
        state_d      = S_IDLE;
      end
      S_TK_SUB: begin
        state_d = S_TK_ADD;
      end
      S_TK_ADD: begin
        if (k_q == CH_LAST) begin
          state_d = ((|fire_q) || (rem_le0 && ie_q[k_q])) ? S_TK_OUT : S_IDLE;
        end else begin
          state_d = S_TK_SUB;
        end
      end
      S_TK_OUT: begin
        out_valid_o  = fire_q[k_q];
        kind_o       = KIND_IRQ;
        irq_vector_o = 8'(vector_base_q + {5'd0, k_q, 1'b0});
        last_o       = fire_q[k_q] && !later_fire;
        if (last_o || k_q == CH_LAST) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vector_base_q <= VECTOR_BASE_RST;
      k_q           <= '0;
      it_q          <= '0;
      fire_q        <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        ie_q[c]   <= 1'b0;
        run_q[c]  <= 1'b0;
        cs_q[c]   <= 1'b0;
        pend_q[c] <= 1'b0;
        tc_q[c]   <= '0;
        ps_q[c]   <= PS_NONE;
        op_q[c]   <= '0;
        rem_q[c]  <= '0;
        ip_q[c]   <= (c < 2) ? PERIOD_BITS'(IP_RST_SYSCLK) : PERIOD_BITS'(IP_RST_CASCADE);
      end
    end else begin
      if (cfg_we_i) vector_base_q <= cfg_data_i;
      case (state_q)
        S_IDLE: begin
          it_q   <= '0;
          fire_q <= '0;
          k_q    <= (cmd_i == CMD_READ) ? channel_i : '0;
          if (accept && cmd_i == CMD_WRITE) begin
            if (pend_q[channel_i]) begin
              pend_q[channel_i] <= 1'b0;
              tc_q[channel_i]   <= data_i;
              run_q[channel_i]  <= 1'b1;
            end else begin
              ie_q[channel_i] <= data_i[CTRL_IE];
              if (data_i[CTRL_CASCADE]) begin
                cs_q[channel_i] <= 1'b0;
                ps_q[channel_i] <= PS_1;
              end else begin
                cs_q[channel_i] <= 1'b1;
                ps_q[channel_i] <= data_i[CTRL_PRE256] ? PS_256 : PS_16;
              end
              pend_q[channel_i] <= data_i[CTRL_TC_FOLLOWS];
              run_q[channel_i]  <= !data_i[CTRL_STOP];
            end
          end
        end
        S_MUL: begin
          it_q <= it_q + ITW'(1);
        end
        S_MUL_END: begin
          // commit period, reload count, feed the cascade
          op_q[k_q]  <= prod;
          rem_q[k_q] <= {1'b0, prod};
          if (k_q == CH_CASC_SRC_A) ip_q[CH_CASC_DST_A] <= prod;
          if (k_q == CH_CASC_SRC_B) ip_q[CH_CASC_DST_B] <= prod;
          k_q  <= k_q + CHAN_W'(1);
          it_q <= '0;
        end
        S_DIV: begin
          it_q <= it_q + ITW'(1);
        end
        S_TK_SUB: begin
          if (run_q[k_q]) rem_q[k_q] <= rem_after_sub;
        end
        S_TK_ADD: begin
          if (rem_le0) begin
            rem_q[k_q]  <= alu_sum[RW-1:0];
            fire_q[k_q] <= ie_q[k_q];
          end
          k_q <= k_q + CHAN_W'(1);
        end
        S_TK_OUT: begin
          k_q <= k_q + CHAN_W'(1);
        end
        default: begin
          it_q <= '0;
        end
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        acc_q    <= '0;
        quo_q    <= '0;
        cycles_q <= cycles_i;
        neg_q    <= rem_sel[RW-1];
        n_q      <= rem_sel[RW-1] ? RW'(~rem_sel + RW'(1)) : rem_sel;
      end
      S_MUL: begin
        acc_q <= alu_sum;
      end
      S_MUL_END: begin
        acc_q <= '0;
      end
      S_DIV: begin
        acc_q <= div_ge ? W'(alu_sum[RW-1:0])
                        : W'({acc_q[PERIOD_BITS-1:0], n_q[RW-1]});
        n_q   <= n_q << 1;
        quo_q <= {quo_q[6:0], div_ge};
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_valid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_o)
    else $error("result strobed while idle");

  a_read_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_READ) |-> last_o)
    else $error("read reply not marked last");

  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |=> (!out_valid_o && !busy_o))
    else $error("activity after last result");

  a_write_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CMD_WRITE) |=> (state_q == S_MUL && k_q == '0))
    else $error("write did not start recompute at channel 0");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/cctc_alu.sv
`default_nettype none

// Shared adder: one step of shift-add multiply, restoring divide,
// or a plain subtract/add on the sign-extended count.
module cctc_alu
  import cctc_pkg::*;
#(
  parameter int PERIOD_BITS = PERIOD_BITS_DEF,
  localparam int W = PERIOD_BITS + ACC_EXT_BITS
) (
  input  alu_mode_e              mode_i,
  input  logic [W-1:0]           acc_i,
  input  logic [PERIOD_BITS-1:0] opnd_i,
  input  logic                   bit_i,
  output logic [W-1:0]           sum_o
);

  logic [W-1:0] a;
  logic [W-1:0] b;
  logic         cin;

  always_comb begin
    a   = acc_i;
    b   = W'(opnd_i);
    cin = 1'b0;
    case (mode_i)
      ALU_MUL: begin
        a = acc_i << 1;
        b = bit_i ? W'(opnd_i) : '0;
      end
      ALU_DIV: begin
        a   = W'({acc_i[PERIOD_BITS-1:0], bit_i});
        b   = ~W'(opnd_i);
        cin = 1'b1;
      end
      ALU_SUB: begin
        b   = ~W'(opnd_i);
        cin = 1'b1;
      end
      ALU_ADD: begin
        b = W'(opnd_i);
      end
      default: begin
        b = '0;
      end
    endcase
  end

  assign sum_o = a + b + W'(cin);

endmodule

`default_nettype wire
